// ===== hdl/ssp_pkg.sv =====
// Shared widths, constants, register codes and pipeline sideband type for the stereo spatializer.
package ssp_pkg;

	localparam int POS_W   = 16;
	localparam int ENT_W   = 12;
	localparam int VOL_W   = 8;
	localparam int ATT_W   = 25;
	localparam int OUT_W   = 9;
	localparam int CIDX_W  = 3;
	localparam int DIFF_W  = 17;
	localparam int SQ_W    = 34;
	localparam int DOT_W   = 35;
	localparam int LEN_W   = 17;
	localparam int PROD_W  = 42;
	localparam int OMD_W   = 25;
	localparam int Q_W     = 14;
	localparam int SCALE_W = 16;
	localparam int MO_W    = 33;
	localparam int PL_W    = 49;
	localparam int VSHIFT  = 38;

	localparam logic [OMD_W-1:0]   Q24_ONE = OMD_W'(25'd16777216);
	localparam logic [SCALE_W-1:0] Q14_ONE = SCALE_W'(16'd16384);
	localparam logic [OUT_W-1:0]   OUT_MAX = OUT_W'(9'd510);

	typedef enum logic [CIDX_W-1:0] {
		REG_LISTENER_X = 3'd0,
		REG_LISTENER_Y = 3'd1,
		REG_LISTENER_Z = 3'd2,
		REG_RIGHT_X    = 3'd3,
		REG_RIGHT_Y    = 3'd4,
		REG_RIGHT_Z    = 3'd5,
		REG_VIEW       = 3'd6,
		REG_MONO       = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                    view;
		logic                    mono;
		logic [VOL_W-1:0]        master;
		logic [ATT_W-1:0]        atten;
		logic signed [DOT_W-1:0] dot;
		logic [LEN_W-1:0]        len;
		logic                    dot_neg;
		logic                    sat;
		logic                    omd_pos;
		logic [OMD_W-1:0]        omd;
	} sb_t;

endpackage

// ===== hdl/stereo_spatializer_core.sv =====
// Top level of the stereo spatializer: config registers, arithmetic stages, root and divider pipes.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------------
//  input    | in_valid / in_ready  | src_x src_y src_z entity_id master_volume
//           |                      | attenuation_scale
//  output   | out_valid/ out_ready | left_volume right_volume
//  config   | cfg_valid/ cfg_ready | cfg_index cfg_data
//
// One transaction per cycle while the output is not stalled; 3 front stages, 17 root stages,
// 2 stages, 14 divider stages, 2 multiply stages and the output register.
// The whole pipe advances together while the output register is empty or taken;
// empty stages carry a cleared valid bit. Reset clears valid bits and config, but right x resets to Q14_ONE.
// Config is always accepted.
module stereo_spatializer_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [ssp_pkg::POS_W-1:0] src_x,
	input  logic signed [ssp_pkg::POS_W-1:0] src_y,
	input  logic signed [ssp_pkg::POS_W-1:0] src_z,
	input  logic [ssp_pkg::ENT_W-1:0]      entity_id,
	input  logic [ssp_pkg::VOL_W-1:0]      master_volume,
	input  logic [ssp_pkg::ATT_W-1:0]      attenuation_scale,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ssp_pkg::OUT_W-1:0]      left_volume,
	output logic [ssp_pkg::OUT_W-1:0]      right_volume,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ssp_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [ssp_pkg::POS_W-1:0]      cfg_data
);
	import ssp_pkg::*;

	logic signed [POS_W-1:0] lx_q, ly_q, lz_q, rx_q, ry_q, rz_q;
	logic [ENT_W-1:0]        view_q;
	logic                    mono_q;

	logic adv;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q   <= '0;
			ly_q   <= '0;
			lz_q   <= '0;
			rx_q   <= signed'(Q14_ONE);
			ry_q   <= '0;
			rz_q   <= '0;
			view_q <= '0;
			mono_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LISTENER_X: lx_q   <= cfg_data;
				REG_LISTENER_Y: ly_q   <= cfg_data;
				REG_LISTENER_Z: lz_q   <= cfg_data;
				REG_RIGHT_X:    rx_q   <= cfg_data;
				REG_RIGHT_Y:    ry_q   <= cfg_data;
				REG_RIGHT_Z:    rz_q   <= cfg_data;
				REG_VIEW:       view_q <= cfg_data[ENT_W-1:0];
				REG_MONO:       mono_q <= cfg_data[0];
			endcase
		end
	end

	// valid bits of the stages owned here
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_rt, v_dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_rt;
			v_s5 <= v_s4;
			v_s6 <= v_dv;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// stage 1: offsets
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	sb_t                      sb_s1;
	sb_t                      sb_new;

	always_comb begin
		sb_new        = '0;
		sb_new.view   = (entity_id == view_q);
		sb_new.mono   = mono_q;
		sb_new.master = master_volume;
		sb_new.atten  = attenuation_scale;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DIFF_W'(src_x) - DIFF_W'(lx_q);
			dy_s1 <= DIFF_W'(src_y) - DIFF_W'(ly_q);
			dz_s1 <= DIFF_W'(src_z) - DIFF_W'(lz_q);
			sb_s1 <= sb_new;
		end
	end

	// stage 2: squares and dot terms
	logic signed [SQ_W-1:0]  dxe, dye, dze;
	logic signed [DOT_W-1:0] dxd, dyd, dzd, rxd, ryd, rzd;
	logic [SQ_W-1:0]         sqx_s2, sqy_s2, sqz_s2;
	logic signed [DOT_W-1:0] px_s2, py_s2, pz_s2;
	sb_t                     sb_s2;

	assign dxe = SQ_W'(dx_s1);
	assign dye = SQ_W'(dy_s1);
	assign dze = SQ_W'(dz_s1);
	assign dxd = DOT_W'(dx_s1);
	assign dyd = DOT_W'(dy_s1);
	assign dzd = DOT_W'(dz_s1);
	assign rxd = DOT_W'(rx_q);
	assign ryd = DOT_W'(ry_q);
	assign rzd = DOT_W'(rz_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= $unsigned(dxe * dxe);
			sqy_s2 <= $unsigned(dye * dye);
			sqz_s2 <= $unsigned(dze * dze);
			px_s2  <= rxd * dxd;
			py_s2  <= ryd * dyd;
			pz_s2  <= rzd * dzd;
			sb_s2  <= sb_s1;
		end
	end

	// stage 3: sums
	logic [SQ_W-1:0] sq_s3;
	sb_t             sb_s3;
	sb_t             sb_d3;

	always_comb begin
		sb_d3     = sb_s2;
		sb_d3.dot = px_s2 + py_s2 + pz_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s3 <= sqx_s2 + sqy_s2 + sqz_s2;
			sb_s3 <= sb_d3;
		end
	end

	logic [LEN_W-1:0] len_rt;
	sb_t              sb_rt;

	ssp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_s3),
		.rad    (sq_s3),
		.sb_in  (sb_s3),
		.v_out  (v_rt),
		.root   (len_rt),
		.sb_out (sb_rt)
	);

	// stage 4: distance product and dot magnitude
	logic [PROD_W-1:0] prod_s4;
	logic [DOT_W-1:0]  adot_s4;
	sb_t               sb_s4;
	sb_t               sb_d4;

	always_comb begin
		sb_d4         = sb_rt;
		sb_d4.len     = len_rt;
		sb_d4.dot_neg = sb_rt.dot[DOT_W-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s4 <= PROD_W'(len_rt) * PROD_W'(sb_rt.atten);
			adot_s4 <= sb_rt.dot[DOT_W-1] ? $unsigned(-sb_rt.dot) : $unsigned(sb_rt.dot);
			sb_s4   <= sb_d4;
		end
	end

	// stage 5: 1 - dist, pan saturation test
	logic [DOT_W-1:0] num_s5;
	sb_t              sb_s5;
	sb_t              sb_d5;

	always_comb begin
		sb_d5         = sb_s4;
		sb_d5.omd_pos = (prod_s4[PROD_W-1:OMD_W-1] == '0);
		sb_d5.omd     = Q24_ONE - prod_s4[OMD_W-1:0];
		sb_d5.sat     = (sb_s4.len != '0) && (adot_s4 >= (DOT_W'(sb_s4.len) << Q_W));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5 <= adot_s4;
			sb_s5  <= sb_d5;
		end
	end

	logic [Q_W-1:0] q_dv;
	sb_t            sb_dv;

	ssp_pdiv u_pdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_s5),
		.num    (num_s5),
		.sb_in  (sb_s5),
		.v_out  (v_dv),
		.quot   (q_dv),
		.sb_out (sb_dv)
	);

	// stage 6: pan scales, master times (1 - dist)
	logic [SCALE_W-1:0] pm;
	logic [SCALE_W-1:0] scl_s6, scr_s6;
	logic [MO_W-1:0]    mo_s6;
	logic               view_s6, view_s7;
	logic [VOL_W-1:0]   mst_s6, mst_s7;

	always_comb begin
		if (sb_dv.len == '0 || sb_dv.mono) begin
			pm = '0;
		end else if (sb_dv.sat) begin
			pm = Q14_ONE;
		end else begin
			pm = SCALE_W'(q_dv);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scl_s6  <= sb_dv.dot_neg ? Q14_ONE + pm : Q14_ONE - pm;
			scr_s6  <= sb_dv.dot_neg ? Q14_ONE - pm : Q14_ONE + pm;
			mo_s6   <= sb_dv.omd_pos ? MO_W'(sb_dv.master) * MO_W'(sb_dv.omd) : '0;
			view_s6 <= sb_dv.view;
			mst_s6  <= sb_dv.master;
		end
	end

	// stage 7: full products
	logic [PL_W-1:0] pl_s7, pr_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			pl_s7   <= PL_W'(mo_s6) * PL_W'(scl_s6);
			pr_s7   <= PL_W'(mo_s6) * PL_W'(scr_s6);
			view_s7 <= view_s6;
			mst_s7  <= mst_s6;
		end
	end

	// stage 8: output register
	logic [PL_W-VSHIFT-1:0] lt, rt;
	logic [OUT_W-1:0]       left_s8, right_s8;

	assign lt = pl_s7[PL_W-1:VSHIFT];
	assign rt = pr_s7[PL_W-1:VSHIFT];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (view_s7) begin
				left_s8  <= OUT_W'(mst_s7);
				right_s8 <= OUT_W'(mst_s7);
			end else begin
				left_s8  <= (lt > (PL_W-VSHIFT)'(OUT_MAX)) ? OUT_MAX : lt[OUT_W-1:0];
				right_s8 <= (rt > (PL_W-VSHIFT)'(OUT_MAX)) ? OUT_MAX : rt[OUT_W-1:0];
			end
		end
	end

	assign out_valid    = v_s8;
	assign left_volume  = left_s8;
	assign right_volume = right_s8;

`ifndef NO_ASSERTIONS
	a_in_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction did not enter the pipe");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (left_volume <= OUT_MAX) && (right_volume <= OUT_MAX))
		else $error("volume above clamp");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_volume) && $stable(right_volume)
			&& $stable(v_s7))
		else $error("pipe moved during stall");
`endif

endmodule

// ===== hdl/ssp_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module ssp_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      v_in,
	input  logic [ssp_pkg::SQ_W-1:0]  rad,
	input  ssp_pkg::sb_t              sb_in,
	output logic                      v_out,
	output logic [ssp_pkg::LEN_W-1:0] root,
	output ssp_pkg::sb_t              sb_out
);
	import ssp_pkg::*;

	logic             v_s   [LEN_W+1];
	logic [SQ_W-1:0]  rem_s [LEN_W+1];
	logic [LEN_W-1:0] res_s [LEN_W+1];
	sb_t              sb_s  [LEN_W+1];

	assign v_s[0]   = v_in;
	assign rem_s[0] = rad;
	assign res_s[0] = '0;
	assign sb_s[0]  = sb_in;

	for (genvar g = 0; g < LEN_W; g++) begin : g_stage
		localparam int B = LEN_W - 1 - g;
		logic [SQ_W-1:0] trial;
		// (2*res + 2^B) * 2^B
		assign trial = (SQ_W'(res_s[g]) << (B + 1)) | (SQ_W'(1) << (2 * B));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sb_s[g+1] <= sb_s[g];
				if (rem_s[g] >= trial) begin
					rem_s[g+1] <= rem_s[g] - trial;
					res_s[g+1] <= res_s[g] | (LEN_W'(1) << B);
				end else begin
					rem_s[g+1] <= rem_s[g];
					res_s[g+1] <= res_s[g];
				end
			end
		end
	end

	assign v_out  = v_s[LEN_W];
	assign root   = res_s[LEN_W];
	assign sb_out = sb_s[LEN_W];

endmodule

// ===== hdl/ssp_pdiv.sv =====
// Pipelined restoring divider: magnitude of the dot product over the length, one quotient bit per stage.
module ssp_pdiv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic                      v_in,
	input  logic [ssp_pkg::DOT_W-1:0] num,
	input  ssp_pkg::sb_t              sb_in,
	output logic                      v_out,
	output logic [ssp_pkg::Q_W-1:0]   quot,
	output ssp_pkg::sb_t              sb_out
);
	import ssp_pkg::*;

	logic             v_s   [Q_W+1];
	logic [DOT_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0]   q_s   [Q_W+1];
	sb_t              sb_s  [Q_W+1];

	assign v_s[0]   = v_in;
	assign rem_s[0] = num;
	assign q_s[0]   = '0;
	assign sb_s[0]  = sb_in;

	// quotient only valid when below 2^14; larger ones are flagged as saturated upstream
	for (genvar g = 0; g < Q_W; g++) begin : g_stage
		localparam int B = Q_W - 1 - g;
		logic [DOT_W-1:0] dsh;
		assign dsh = DOT_W'(sb_s[g].len) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (adv) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sb_s[g+1] <= sb_s[g];
				if (rem_s[g] >= dsh) begin
					rem_s[g+1] <= rem_s[g] - dsh;
					q_s[g+1]   <= q_s[g] | (Q_W'(1) << B);
				end else begin
					rem_s[g+1] <= rem_s[g];
					q_s[g+1]   <= q_s[g];
				end
			end
		end
	end

	assign v_out  = v_s[Q_W];
	assign quot   = q_s[Q_W];
	assign sb_out = sb_s[Q_W];

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the stereo spatializer core: random and directed sources, scoreboard.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ssp_pkg::*;

	localparam int LATENCY   = 39;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 530;

	typedef struct {
		logic signed [POS_W-1:0] x, y, z;
		logic [ENT_W-1:0]        ent;
		logic [VOL_W-1:0]        master;
		logic [ATT_W-1:0]        atten;
	} source_t;

	typedef struct {
		logic [OUT_W-1:0] left, right;
	} volumes_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic signed [POS_W-1:0] src_x = '0, src_y = '0, src_z = '0;
	logic [ENT_W-1:0] entity_id = '0;
	logic [VOL_W-1:0] master_volume = '0;
	logic [ATT_W-1:0] attenuation_scale = '0;
	logic out_valid, out_ready = 1'b0;
	logic [OUT_W-1:0] left_volume, right_volume;
	logic cfg_valid = 1'b0, cfg_ready;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [POS_W-1:0] cfg_data = '0;

	stereo_spatializer_core dut (.*);

	always #6 clk = ~clk;

	// listener state as the predictor sees it
	longint lis_x, lis_y, lis_z, rgt_x, rgt_y, rgt_z;
	int unsigned view_ent;
	bit mono_mode;

	source_t  pending_sources[$];
	volumes_t expected_volumes[$];
	int errors = 0, n_accepted = 0, n_checked = 0, wdog = 0;
	int send_idle_pct = 14, recv_idle_pct = 54;
	bit feeding = 1'b0;
	// input transaction taken at the last rising edge
	bit in_taken = 1'b0;

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res = 0, bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint side_gain(longint master, longint omd, longint scale);
		longint p;
		if (omd <= 0 || scale <= 0) return 0;
		p = (master * omd * scale) >>> 38;
		return (p > 510) ? 510 : p;
	endfunction

	function automatic volumes_t spatialize(source_t s);
		volumes_t v;
		longint dx, dy, dz, len, omd, pan, dot;
		dx = longint'(s.x) - lis_x;
		dy = longint'(s.y) - lis_y;
		dz = longint'(s.z) - lis_z;
		pan = 0;
		if (s.ent == view_ent) begin
			v.left = OUT_W'(s.master);
			v.right = OUT_W'(s.master);
			return v;
		end
		len = int_sqrt(longint'(dx*dx + dy*dy + dz*dz));
		omd = 64'sd16777216 - len * longint'(s.atten);
		if (len != 0) begin
			dot = rgt_x*dx + rgt_y*dy + rgt_z*dz;
			pan = dot / len;   // truncates toward zero
			if (pan > 16384) pan = 16384;
			if (pan < -16384) pan = -16384;
		end
		if (mono_mode) pan = 0;
		v.left  = OUT_W'(side_gain(s.master, omd, 16384 - pan));
		v.right = OUT_W'(side_gain(s.master, omd, 16384 + pan));
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
	endtask

	// driver
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (feeding && pending_sources.size() > 0 &&
			    $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				src_x <= pending_sources[0].x;
				src_y <= pending_sources[0].y;
				src_z <= pending_sources[0].z;
				entity_id <= pending_sources[0].ent;
				master_volume <= pending_sources[0].master;
				attenuation_scale <= pending_sources[0].atten;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// monitor and watchdog
	always @(posedge clk) begin
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			expected_volumes.push_back(spatialize(pending_sources.pop_front()));
			n_accepted++;
		end
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				wdog <= 0;
			else
				wdog <= wdog + 1;
			if (wdog >= WDOG_MAX) begin
				$display("watchdog expired, %0d results outstanding", expected_volumes.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
		if (out_valid && out_ready) begin
			if (expected_volumes.size() == 0) begin
				report_mismatch("unexpected result, left", left_volume, -1);
			end else begin
				volumes_t e;
				e = expected_volumes.pop_front();
				if (left_volume !== e.left) report_mismatch("left", left_volume, e.left);
				if (right_volume !== e.right) report_mismatch("right", right_volume, e.right);
			end
			n_checked++;
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [POS_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_LISTENER_X: lis_x = longint'($signed(data));
			REG_LISTENER_Y: lis_y = longint'($signed(data));
			REG_LISTENER_Z: lis_z = longint'($signed(data));
			REG_RIGHT_X:    rgt_x = longint'($signed(data));
			REG_RIGHT_Y:    rgt_y = longint'($signed(data));
			REG_RIGHT_Z:    rgt_z = longint'($signed(data));
			REG_VIEW:       view_ent = 32'(data[ENT_W-1:0]);
			REG_MONO:       mono_mode = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_sources.size() > 0 || in_valid || expected_volumes.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic source_t rand_source(int pos_span, int view_pct);
		source_t s;
		int c = pos_span;
		s.x = (c == 0) ? POS_W'($urandom) : POS_W'(lis_x + $signed($urandom_range(2*c)) - c);
		s.y = (c == 0) ? POS_W'($urandom) : POS_W'(lis_y + $signed($urandom_range(2*c)) - c);
		s.z = (c == 0) ? POS_W'($urandom) : POS_W'(lis_z + $signed($urandom_range(2*c)) - c);
		s.ent = ($urandom_range(99) < view_pct) ? ENT_W'(view_ent) : ENT_W'($urandom);
		s.master = VOL_W'($urandom);
		case ($urandom_range(3))
			0: s.atten = ATT_W'($urandom);
			1: s.atten = ATT_W'($urandom_range(20000));
			2: s.atten = ATT_W'($urandom_range(16777216));
			default: s.atten = ATT_W'($urandom_range(300));
		endcase
		return s;
	endfunction

	function automatic source_t mk(int x, int y, int z, int e, int m, int a);
		source_t s;
		s.x = POS_W'(x); s.y = POS_W'(y); s.z = POS_W'(z);
		s.ent = ENT_W'(e); s.master = VOL_W'(m); s.atten = ATT_W'(a);
		return s;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			pending_sources.push_back(rand_source($urandom_range(1) ? 0 : 3000, 8));
			// one pause until every result is back
			if (i == n/2) begin
				while (pending_sources.size() > 0 || in_valid || expected_volumes.size() > 0)
					@(posedge clk);
			end
		end
		drain();
	endtask

	initial begin
		lis_x = 0; lis_y = 0; lis_z = 0;
		rgt_x = 16384; rgt_y = 0; rgt_z = 0;
		view_ent = 0; mono_mode = 0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		feeding = 1'b1;

		// directed: defaults, then extremes of every field
		write_reg(REG_VIEW, 16'd4095);
		pending_sources.push_back(mk(0, 0, 0, 1, 255, 0));              // zero offset
		pending_sources.push_back(mk(100, 0, 0, 4095, 200, 1000));      // view entity
		pending_sources.push_back(mk(100, 0, 0, 0, 255, 0));            // hard right
		pending_sources.push_back(mk(-100, 0, 0, 0, 255, 0));           // hard left
		pending_sources.push_back(mk(32767, 32767, 32767, 7, 255, 1));
		pending_sources.push_back(mk(-32768, -32768, -32768, 8, 255, 2));
		pending_sources.push_back(mk(1000, 0, 0, 9, 255, 16777216));   // far source
		pending_sources.push_back(mk(1, 0, 0, 9, 255, 33554431));     // attenuation above one
		pending_sources.push_back(mk(3, 4, 0, 10, 128, 16384));
		pending_sources.push_back(mk(0, 0, 5, 11, 0, 100));
		pending_sources.push_back(mk(-1, 1, -1, 4094, 1, 0));
		drain();
		write_reg(REG_LISTENER_X, 16'h8000);
		write_reg(REG_LISTENER_Y, 16'h7FFF);
		write_reg(REG_LISTENER_Z, 16'h8000);
		write_reg(REG_RIGHT_X, 16'h4000);
		write_reg(REG_RIGHT_Y, 16'h4000);   // over-long right vector: pan saturates
		write_reg(REG_RIGHT_Z, 16'hC000);
		write_reg(REG_VIEW, 16'd0);
		pending_sources.push_back(mk(32767, -32768, 32767, 5, 255, 0));
		pending_sources.push_back(mk(-32768, 32767, -32768, 5, 255, 0));
		pending_sources.push_back(mk(-32767, 32767, -32768, 6, 255, 3));
		drain();
		write_reg(REG_MONO, 16'd1);
		pending_sources.push_back(mk(0, 0, 0, 5, 255, 100));
		pending_sources.push_back(mk(-32000, 32000, 0, 5, 255, 100));
		drain();

		// random phases over several listener settings
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 54 : 0;
			recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 14 : 0;
			write_reg(REG_LISTENER_X, POS_W'($urandom));
			write_reg(REG_LISTENER_Y, POS_W'($urandom));
			write_reg(REG_LISTENER_Z, POS_W'($urandom));
			write_reg(REG_RIGHT_X, POS_W'($urandom_range(32768) - 16384));
			write_reg(REG_RIGHT_Y, POS_W'($urandom_range(32768) - 16384));
			write_reg(REG_RIGHT_Z, POS_W'($urandom_range(32768) - 16384));
			write_reg(REG_VIEW, POS_W'($urandom_range(4095)));
			write_reg(REG_MONO, POS_W'(ph == 2));
			run_random(N_RANDOM / 3);
		end

		$display("covered %0d sources, %0d results checked, over directed extremes", n_accepted,
			n_checked);
		$display("and three random phases with varied listener, stalls and mono mode");
		if (errors == 0 && expected_volumes.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors, %0d results missing", errors, expected_volumes.size());
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
